>>> design/json_string_escaper_macros.svh
// Assertion macros for the JSON string escaper checker.
// Needs clk and rst_n in scope where the macros are used.
`ifndef JSON_STRING_ESCAPER_MACROS_SVH
`define JSON_STRING_ESCAPER_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define JSE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent completes.
`define JSE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/jse_pkg.sv
// Shared types, constants and helper functions for the JSON string escaper.
// No dependencies.
package jse_pkg;

  localparam int COUNT_BITS_DEF = 16;
  localparam int SEGS           = 4;
  localparam logic [15:0] CAP_RESET = 16'd256;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_ZERO   = 8'h30;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_item_t;

  // One output segment: a literal byte, a backslash pair or a \u00xx escape
  typedef enum logic [1:0] {
    SEG_LIT,
    SEG_PAIR,
    SEG_UESC
  } seg_kind_t;

  typedef struct packed {
    logic       present;
    seg_kind_t  kind;
    logic [7:0] data;
  } seg_t;

  // UTF-8 hold state and stop flag
  typedef struct packed {
    logic [2:0][7:0] held;
    logic [1:0]      held_cnt;
    logic [2:0]      seq_len;
    logic            stopped;
  } hold_state_t;

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    hex_char = (n < 4'd10) ? (8'h30 + {4'h0, n}) : (8'h57 + {4'h0, n});
  endfunction

  // Expected sequence length of a UTF-8 lead, zero if not a lead
  function automatic logic [2:0] lead_len(input logic [7:0] b);
    if ((b & 8'hE0) == 8'hC0) begin
      lead_len = 3'd2;
    end else if ((b & 8'hF0) == 8'hE0) begin
      lead_len = 3'd3;
    end else if ((b & 8'hF8) == 8'hF0) begin
      lead_len = 3'd4;
    end else begin
      lead_len = 3'd0;
    end
  endfunction

  // {hit, second char of the backslash pair}
  function automatic logic [8:0] esc_char(input logic [7:0] b);
    case (b)
      8'h27:   esc_char = {1'b1, 8'h27};
      8'h22:   esc_char = {1'b1, 8'h22};
      8'h2F:   esc_char = {1'b1, 8'h2F};
      8'h5C:   esc_char = {1'b1, 8'h5C};
      8'h08:   esc_char = {1'b1, 8'h62};
      8'h0C:   esc_char = {1'b1, 8'h66};
      8'h0A:   esc_char = {1'b1, 8'h6E};
      8'h0D:   esc_char = {1'b1, 8'h72};
      8'h09:   esc_char = {1'b1, 8'h74};
      default: esc_char = 9'h000;
    endcase
  endfunction

  function automatic logic [2:0] seg_len(input seg_kind_t k);
    case (k)
      SEG_LIT:  seg_len = 3'd1;
      SEG_PAIR: seg_len = 3'd2;
      SEG_UESC: seg_len = 3'd6;
      default:  seg_len = 3'd1;
    endcase
  endfunction

endpackage

>>> design/json_string_escaper.sv
// An accepted item is held in the input register, then decoded into the result buffer.
// Throughput: one item per cycle while each item gives at most one byte and the result
// channel is not stalled; an item that gives n bytes (up to 24) holds the result buffer
// until all are sent, the result channel carrying one byte per cycle when not stalled.
// Reset (synchronous, active low): clears held bytes, count and stop flag; the
// capacity register returns to 256.
module json_string_escaper #(
  parameter int COUNT_BITS = jse_pkg::COUNT_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  jse_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output jse_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data
);
  import jse_pkg::*;

  in_item_t              in_r, in_nxt;
  logic                  in_full_r, in_full_nxt;
  hold_state_t           st_r, st_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [15:0]           cap_r, cap_nxt;

  seg_t [3:0]            segs;
  logic                  any_out;
  logic                  ser_ready;
  logic                  adv;
  logic                  step;
  logic                  in_acc;

  jse_decode #(
    .COUNT_BITS (COUNT_BITS)
  ) u_decode (
    .item    (in_r),
    .st      (st_r),
    .cnt     (cnt_r),
    .cap     (cap_r),
    .segs    (segs),
    .any_out (any_out),
    .st_nxt  (st_nxt),
    .cnt_nxt (cnt_nxt)
  );

  jse_serial u_serial (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step && any_out),
    .segs      (segs),
    .ready     (ser_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // items with no result bytes move on without the result buffer
  assign adv       = !any_out || ser_ready;
  assign step      = in_full_r && adv;
  assign in_stall  = in_full_r && !adv;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_comb begin
    in_nxt      = in_acc ? in_item : in_r;
    in_full_nxt = in_acc ? 1'b1 : (step ? 1'b0 : in_full_r);
    cap_nxt     = cfg_valid ? cfg_data : cap_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r <= 1'b0;
      st_r      <= '0;
      cnt_r     <= '0;
      cap_r     <= CAP_RESET;
    end else begin
      in_full_r <= in_full_nxt;
      cap_r     <= cap_nxt;
      if (step) begin
        st_r  <= st_nxt;
        cnt_r <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    in_r <= in_nxt;
  end

endmodule

>>> design/jse_decode.sv
// Combinational decode of one item: builds up to four output segments,
// applies the capacity checks and works out the next hold state and count. Uses jse_pkg.
module jse_decode #(
  parameter int COUNT_BITS = 16
) (
  input  jse_pkg::in_item_t           item,
  input  jse_pkg::hold_state_t        st,
  input  logic [COUNT_BITS-1:0]       cnt,
  input  logic [15:0]                 cap,
  output jse_pkg::seg_t [3:0]         segs,
  output logic                        any_out,
  output jse_pkg::hold_state_t        st_nxt,
  output logic [COUNT_BITS-1:0]       cnt_nxt
);
  import jse_pkg::*;

  localparam int CW = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 1;
  localparam logic [CW-1:0] MARGIN = CW'(8);

  typedef struct packed {
    logic       valid;
    logic       check;
    logic       emit;
    seg_kind_t  kind;
    logic [7:0] data;
  } op_t;

  logic [7:0]          b;
  logic                fin;
  logic                is_cont;
  logic                nul;
  logic                seq_path;
  logic                complete;
  logic                store;
  logic [2:0]          llen;
  logic [8:0]          esc;
  op_t                 bop;
  op_t [3:0]           ops;
  logic [COUNT_BITS-1:0] c;
  logic [COUNT_BITS:0] sum;
  logic                dead;
  logic                stop_hit;

  always_comb begin
    b        = item.in_byte;
    fin      = item.end_of_input;
    is_cont  = (b[7:6] == 2'b10);
    nul      = (b == 8'h00);
    llen     = lead_len(b);
    esc      = esc_char(b);
    seq_path = (st.held_cnt != 2'd0) && is_cont;
    complete = seq_path && (({1'b0, st.held_cnt} + 3'd1) >= st.seq_len);
    store    = seq_path && !complete;

    // operation for the current byte, placed after any held bytes
    bop      = '0;
    bop.data = b;
    if (nul) begin
      bop.valid = 1'b0;
    end else if (complete) begin
      bop.valid = 1'b1;
      bop.emit  = 1'b1;
      bop.kind  = SEG_LIT;
    end else if (store) begin
      // held continuation only escaped when the string ends here
      bop.valid = fin;
      bop.check = 1'b1;
      bop.emit  = 1'b1;
      bop.kind  = SEG_UESC;
    end else begin
      bop.valid = 1'b1;
      bop.check = 1'b1;
      if (llen != 3'd0) begin
        bop.emit = fin;
        bop.kind = SEG_UESC;
      end else begin
        bop.emit = 1'b1;
        if (b[7]) begin
          bop.kind = SEG_UESC;
        end else if (esc[8]) begin
          bop.kind = SEG_PAIR;
          bop.data = esc[7:0];
        end else if (b <= 8'h1F || b == 8'h7F) begin
          bop.kind = SEG_UESC;
        end else begin
          bop.kind = SEG_LIT;
        end
      end
    end
    bop.valid = bop.valid && !st.stopped;

    ops = '0;
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < st.held_cnt) begin
        ops[i].valid = !st.stopped && !(store && !fin);
        ops[i].check = !complete && (i != 0);
        ops[i].emit  = 1'b1;
        ops[i].kind  = complete ? SEG_LIT : SEG_UESC;
        ops[i].data  = st.held[i];
      end
    end
    ops[st.held_cnt] = bop;

    // walk the operations; a failed room check stops and drops the rest
    c        = cnt;
    dead     = 1'b0;
    stop_hit = 1'b0;
    sum      = '0;
    for (int i = 0; i < SEGS; i++) begin
      segs[i].present = 1'b0;
      segs[i].kind    = ops[i].kind;
      segs[i].data    = ops[i].data;
      if (ops[i].valid && !dead) begin
        if (ops[i].check && ((CW'(c) + MARGIN) > CW'(cap))) begin
          dead     = 1'b1;
          stop_hit = 1'b1;
        end else if (ops[i].emit) begin
          segs[i].present = 1'b1;
          sum = {1'b0, c} + (COUNT_BITS + 1)'(seg_len(ops[i].kind));
          c   = sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];
        end
      end
    end
    any_out = segs[0].present | segs[1].present | segs[2].present | segs[3].present;

    st_nxt  = st;
    cnt_nxt = c;
    if (!st.stopped) begin
      if (nul) begin
        st_nxt.held_cnt = 2'd0;
        st_nxt.seq_len  = 3'd0;
        st_nxt.stopped  = 1'b1;
      end else if (complete) begin
        st_nxt.held_cnt = 2'd0;
        st_nxt.seq_len  = 3'd0;
      end else if (store) begin
        if (st.held_cnt != 2'd3) begin
          st_nxt.held[st.held_cnt] = b;
          st_nxt.held_cnt          = st.held_cnt + 2'd1;
        end
      end else if (stop_hit) begin
        st_nxt.held_cnt = 2'd0;
        st_nxt.seq_len  = 3'd0;
        st_nxt.stopped  = 1'b1;
      end else if (llen != 3'd0) begin
        st_nxt.held[0]  = b;
        st_nxt.held_cnt = 2'd1;
        st_nxt.seq_len  = llen;
      end else begin
        st_nxt.held_cnt = 2'd0;
        st_nxt.seq_len  = 3'd0;
      end
    end
    if (fin) begin
      st_nxt  = '0;
      cnt_nxt = '0;
    end
  end

endmodule

>>> design/jse_serial.sv
// Result buffer: holds one item's segments and sends them one byte per cycle
// while the output is not stalled. Uses jse_pkg.
module jse_serial (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  jse_pkg::seg_t [3:0]   segs,
  output logic                  ready,
  output logic                  out_valid,
  input  logic                  out_stall,
  output jse_pkg::out_item_t    out_item
);
  import jse_pkg::*;

  seg_t [3:0] seg_r, seg_nxt;
  logic       full_r, full_nxt;
  logic [1:0] seg_idx_r, seg_idx_nxt;
  logic [1:0] last_seg_r, last_seg_nxt;
  logic [2:0] byte_idx_r, byte_idx_nxt;

  seg_t       cur;
  logic       last_byte;
  logic       last_seg;
  logic       fire;
  logic       done;

  assign cur       = seg_r[seg_idx_r];
  assign last_byte = (byte_idx_r == (seg_len(cur.kind) - 3'd1));
  assign last_seg  = (seg_idx_r == last_seg_r);
  assign fire      = full_r && !out_stall;
  assign done      = fire && last_byte && last_seg;
  assign ready     = !full_r || done;
  assign out_valid = full_r;

  always_comb begin
    out_item.last_of_run = last_byte && last_seg;
    case (cur.kind)
      SEG_UESC: begin
        case (byte_idx_r)
          3'd0:    out_item.out_byte = CH_BSLASH;
          3'd1:    out_item.out_byte = CH_U;
          3'd4:    out_item.out_byte = hex_char(cur.data[7:4]);
          3'd5:    out_item.out_byte = hex_char(cur.data[3:0]);
          default: out_item.out_byte = CH_ZERO;
        endcase
      end
      SEG_PAIR: begin
        out_item.out_byte = (byte_idx_r == 3'd0) ? CH_BSLASH : cur.data;
      end
      default: out_item.out_byte = cur.data;
    endcase
  end

  always_comb begin
    seg_nxt      = seg_r;
    full_nxt     = full_r;
    seg_idx_nxt  = seg_idx_r;
    byte_idx_nxt = byte_idx_r;
    last_seg_nxt = last_seg_r;
    if (load) begin
      seg_nxt      = segs;
      full_nxt     = 1'b1;
      seg_idx_nxt  = 2'd0;
      byte_idx_nxt = 3'd0;
      // present segments form a prefix
      if (segs[3].present) begin
        last_seg_nxt = 2'd3;
      end else if (segs[2].present) begin
        last_seg_nxt = 2'd2;
      end else if (segs[1].present) begin
        last_seg_nxt = 2'd1;
      end else begin
        last_seg_nxt = 2'd0;
      end
    end else if (done) begin
      full_nxt = 1'b0;
    end else if (fire) begin
      if (last_byte) begin
        seg_idx_nxt  = seg_idx_r + 2'd1;
        byte_idx_nxt = 3'd0;
      end else begin
        byte_idx_nxt = byte_idx_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r     <= 1'b0;
      seg_idx_r  <= 2'd0;
      byte_idx_r <= 3'd0;
      last_seg_r <= 2'd0;
    end else begin
      full_r     <= full_nxt;
      seg_idx_r  <= seg_idx_nxt;
      byte_idx_r <= byte_idx_nxt;
      last_seg_r <= last_seg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    seg_r <= seg_nxt;
  end

endmodule

>>> design/jse_checker.sv
// Port-level checker for the JSON string escaper, bound to the top level.
// Uses jse_pkg and json_string_escaper_macros.svh.
`include "json_string_escaper_macros.svh"

module jse_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input jse_pkg::out_item_t out_item
);

  `JSE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item), "stalled result item changed")
  `JSE_ASSERT_SAME(a_stall_busy, in_stall, out_valid, "input stalled with no result pending")
  `JSE_ASSERT_NEXT(a_run_cont, out_valid && !out_stall && !out_item.last_of_run, out_valid, "run cut short")
  `JSE_ASSERT_NEXT(a_idle_quiet, (!out_valid && !(in_valid && !in_stall)) ##1 (!out_valid && !(in_valid && !in_stall)), !out_valid, "result item without input item")

endmodule

bind json_string_escaper jse_checker u_jse_checker (.*);

>>> test/json_string_escaper_checker.sv
`timescale 1ns / 1ps
// Scoreboard for json_string_escaper: follows the input, result and register channels,
// works out the escaped bytes of every accepted item and compares them with the output.
// Depends on jse_pkg for the item types and the capacity reset value.
module json_string_escaper_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  jse_pkg::in_item_t   in_item,
  input  logic                out_valid,
  input  logic                out_stall,
  input  jse_pkg::out_item_t  out_item,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [15:0]         cfg_data,
  output int                  error_count,
  output int                  bytes_pending
);
  import jse_pkg::*;

  localparam int MAX_RUN = 24;
  localparam logic [7:0] BSLASH = 8'h5C;

  logic [15:0] capacity;
  logic [7:0]  held [3];
  int          held_n;
  int          utf8_len;
  logic [15:0] emitted;
  bit          closed;
  logic [7:0]  run_bytes [$];
  out_item_t   expected_bytes [$];
  int          errors = 0;
  int          pending = 0;

  assign error_count   = errors;
  assign bytes_pending = pending;

  task automatic report_mismatch(string msg);
    $display("ERROR at %0t: %s", $time, msg);
    errors++;
  endtask

  function automatic logic [7:0] hex_digit(logic [3:0] n);
    return (n < 4'd10) ? 8'h30 + 8'(n) : 8'h61 + 8'(n) - 8'd10;
  endfunction

  function automatic void emit(logic [7:0] v);
    if (run_bytes.size() < MAX_RUN) begin
      run_bytes.push_back(v);
      if (emitted != 16'hFFFF) emitted++;
    end
  endfunction

  function automatic void emit_hex_escape(logic [7:0] v);
    emit(BSLASH);
    emit(8'h75);
    emit(8'h30);
    emit(8'h30);
    emit(hex_digit(v[7:4]));
    emit(hex_digit(v[3:0]));
  endfunction

  // closes the string when the buffer margin is used up
  function automatic bit has_room();
    if (32'(emitted) + 32'd8 > 32'(capacity)) begin
      closed = 1'b1;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic bit pair_of(logic [7:0] b, output logic [7:0] c);
    c = b;
    case (b)
      8'h27, 8'h22, 8'h2F, 8'h5C: c = b;
      8'h08: c = 8'h62;
      8'h0C: c = 8'h66;
      8'h0A: c = 8'h6E;
      8'h0D: c = 8'h72;
      8'h09: c = 8'h74;
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  // first held byte was checked on arrival, the rest are checked here
  function automatic void flush_held();
    for (int i = 0; i < held_n; i++) begin
      if (i > 0 && !has_room()) break;
      emit_hex_escape(held[i]);
    end
    held_n   = 0;
    utf8_len = 0;
  endfunction

  function automatic void start_byte(logic [7:0] b);
    logic [7:0] second;
    int len;
    if (!has_room()) return;
    if (b[7]) begin
      casez (b)
        8'b110?_????: len = 2;
        8'b1110_????: len = 3;
        8'b1111_0???: len = 4;
        default:      len = 0;
      endcase
      if (len != 0) begin
        held[0]  = b;
        held_n   = 1;
        utf8_len = len;
      end else begin
        emit_hex_escape(b);
      end
    end else if (pair_of(b, second)) begin
      emit(BSLASH);
      emit(second);
    end else if (b <= 8'h1F || b == 8'h7F) begin
      emit_hex_escape(b);
    end else begin
      emit(b);
    end
  endfunction

  function automatic void clear_string();
    held     = '{default: 8'h00};
    held_n   = 0;
    utf8_len = 0;
    emitted  = '0;
    closed   = 1'b0;
  endfunction

  function automatic void escape_byte(in_item_t it);
    logic [7:0] b;
    b = it.in_byte;
    run_bytes.delete();
    if (!closed) begin
      if (b == 8'h00) begin
        flush_held();
        closed = 1'b1;
      end else if (held_n > 0 && b[7:6] == 2'b10) begin
        // completion skips the room check, it was made on the lead
        if (held_n + 1 >= utf8_len) begin
          for (int k = 0; k < held_n; k++) emit(held[k]);
          emit(b);
          held_n   = 0;
          utf8_len = 0;
        end else if (held_n < 3) begin
          held[held_n] = b;
          held_n++;
        end
      end else begin
        if (held_n > 0) flush_held();
        if (!closed) start_byte(b);
      end
    end
    if (it.end_of_input) begin
      if (!closed) flush_held();
      clear_string();
    end
    for (int k = 0; k < run_bytes.size(); k++) begin
      expected_bytes.push_back(out_item_t'{out_byte: run_bytes[k],
                                           last_of_run: (k == run_bytes.size() - 1)});
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      capacity = CAP_RESET;
      clear_string();
      expected_bytes.delete();
    end else begin
      if (cfg_valid && cfg_ready) capacity = cfg_data;
      // results of an item never leave on its own accept edge
      if (out_valid && !out_stall) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch($sformatf("byte %h with nothing expected", out_item.out_byte));
        end else begin
          want = expected_bytes.pop_front();
          if (out_item.out_byte !== want.out_byte)
            report_mismatch($sformatf("out_byte %h, expected %h",
                                      out_item.out_byte, want.out_byte));
          if (out_item.last_of_run !== want.last_of_run)
            report_mismatch($sformatf("last_of_run %b, expected %b on byte %h",
                                      out_item.last_of_run, want.last_of_run,
                                      want.out_byte));
        end
      end
      if (in_valid && !in_stall) escape_byte(in_item);
    end
    pending <= expected_bytes.size();
  end

endmodule

>>> test/tb_json_string_escaper.sv
`timescale 1ns / 1ps
// Testbench top for json_string_escaper: clock, reset, byte stimulus, register writes
// and verdict. Needs jse_pkg, the block and json_string_escaper_checker.
module tb_json_string_escaper;
  import jse_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_item;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;
  int          errors;
  int          pending;
  int          idle_pct = 27;
  in_item_t    stim_q [$];
  logic [7:0]  pair_src [9] = '{8'h27, 8'h22, 8'h2F, 8'h5C, 8'h08, 8'h0C, 8'h0A, 8'h0D,
                                8'h09};

  json_string_escaper dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  json_string_escaper_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_item       (in_item),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_item      (out_item),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .error_count   (errors),
    .bytes_pending (pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < idle_pct);
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  task automatic add(logic [7:0] b, bit eoi);
    stim_q.push_back(in_item_t'{in_byte: b, end_of_input: eoi});
  endtask

  // valid stays high from one item to the next unless an idle cycle is drawn
  task automatic send_queued();
    in_item_t it;
    while (stim_q.size() != 0) begin
      it = stim_q.pop_front();
      while ($urandom_range(99) < idle_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      in_valid <= 1'b1;
      in_item  <= it;
      do @(posedge clk); while (in_stall);
    end
  endtask

  // extra cycles cover items that leave no result but may still be in flight
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_capacity(logic [15:0] v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic add_utf8(int n, int conts);
    case (n)
      2:       add(8'($urandom_range(8'hC0, 8'hDF)), 1'b0);
      3:       add(8'($urandom_range(8'hE0, 8'hEF)), 1'b0);
      default: add(8'($urandom_range(8'hF0, 8'hF7)), 1'b0);
    endcase
    repeat (conts) add(8'($urandom_range(8'h80, 8'hBF)), 1'b0);
  endtask

  // one string of mostly well-formed text, closed by the end flag or a NUL
  task automatic queue_string(output int counted);
    int len;
    int pick;
    int n;
    len = $urandom_range(1, 24);
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(99);
      if (pick < 38) begin
        add(8'($urandom_range(8'h20, 8'h7E)), 1'b0);
      end else if (pick < 48) begin
        add(pair_src[$urandom_range(8)], 1'b0);
      end else if (pick < 56) begin
        add(($urandom_range(7) == 0) ? 8'h7F : 8'($urandom_range(1, 8'h1F)), 1'b0);
      end else if (pick < 76) begin
        n = $urandom_range(2, 4);
        add_utf8(n, n - 1);
      end else if (pick < 84) begin
        // sequence cut short by whatever comes next
        n = $urandom_range(2, 4);
        add_utf8(n, $urandom_range(0, n - 2));
      end else if (pick < 90) begin
        add(($urandom_range(1) != 0) ? 8'($urandom_range(8'h80, 8'hBF))
                                     : 8'($urandom_range(8'hF8, 8'hFF)), 1'b0);
      end else begin
        add(8'($urandom_range(1, 255)), 1'b0);
      end
    end
    pick = $urandom_range(99);
    if (pick < 60) begin
      stim_q[stim_q.size() - 1].end_of_input = 1'b1;
      counted = stim_q.size();
    end else if (pick < 85) begin
      add(8'h00, 1'b0);
      counted = stim_q.size();
      repeat ($urandom_range(0, 3)) add(8'($urandom), 1'b0);
      add(8'($urandom), 1'b1);
    end else begin
      add(8'h00, 1'b1);
      counted = stim_q.size();
    end
  endtask

  task automatic run_strings(int target);
    int done;
    int n;
    done = 0;
    while (done < target) begin
      queue_string(n);
      send_queued();
      done += n;
    end
  endtask

  initial begin
    logic [7:0] opening [$];
    opening = '{8'h27, 8'h22, 8'h2F, 8'h5C, 8'h08, 8'h0C, 8'h0A, 8'h0D,
                8'h09, 8'h01, 8'h7F, 8'h80, 8'hF8, 8'hC3, 8'hA9, 8'hE2,
                8'h82, 8'hAC, 8'hF0, 8'h9F, 8'h98, 8'h80, 8'hE2, 8'h41,
                8'hE2, 8'h82};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset capacity: every escape, controls, strays, full and broken UTF-8
    foreach (opening[i]) add(opening[i], 1'b0);
    add(8'h00, 1'b0);            // NUL cuts off the held sequence
    add(8'h79, 1'b1);            // ignored while closed, end flag reopens
    add(8'hF0, 1'b0);
    add(8'h9F, 1'b0);
    add(8'h98, 1'b1);            // sequence cut off by the end flag
    send_queued();

    // room runs out part way through a flush
    write_capacity(16'd14);
    add(8'hF0, 1'b0);
    add(8'h9F, 1'b0);
    add(8'h98, 1'b0);
    add(8'h41, 1'b0);
    add(8'h42, 1'b1);
    send_queued();

    // capacity below eight emits nothing
    write_capacity(16'd0);
    add(8'h41, 1'b1);
    send_queued();
    run_strings(15);

    write_capacity(16'd8);
    run_strings(45);

    idle_pct = 0;
    write_capacity(16'hFFFF);
    run_strings(100);
    idle_pct = 27;

    write_capacity(16'($urandom_range(9, 60)));
    run_strings(80);

    write_capacity(16'd256);
    run_strings(80);

    wait_drained();
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
